### sv/bgcd_pkg.sv
// Shared types and constants for the battery charge gauge.
// Holds the open-circuit-voltage table, field widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bgcd_pkg;

    localparam int MV_W   = 13;
    localparam int PCT_W  = 7;
    localparam int TREND_W = 8;
    localparam int IDX_W  = 2;

    typedef logic [MV_W-1:0]  t_mv;
    typedef logic [PCT_W-1:0] t_pct;
    typedef logic [TREND_W-1:0] t_trend;
    typedef logic [IDX_W-1:0] t_idx;

    localparam int TABLE_N = 12;
    localparam int SEG_N   = TABLE_N - 1;
    localparam int SEG_W   = $clog2(TABLE_N);

    typedef logic [SEG_W-1:0] t_seg;

    localparam t_mv  OCV_MV  [TABLE_N] = '{
        13'd3300, 13'd3450, 13'd3550, 13'd3660, 13'd3700, 13'd3740,
        13'd3780, 13'd3820, 13'd3870, 13'd3950, 13'd4080, 13'd4200
    };
    localparam t_pct OCV_PCT [TABLE_N] = '{
        7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
        7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };

    localparam t_mv  EMPTY_MV = 13'd100;
    localparam logic [6:0] FAST_K = 7'd77;
    localparam logic [6:0] SLOW_K = 7'd13;
    localparam t_pct PCT_MAX  = 7'd100;
    localparam t_pct PCT_NONE = 7'd127;

    localparam t_idx REG_FULL_THRESHOLD = 2'd0;
    localparam t_idx REG_RISE_TREND     = 2'd1;
    localparam t_idx REG_FALL_TREND     = 2'd2;

    localparam t_mv    FULL_THRESHOLD_RST = 13'd4150;
    localparam t_trend RISE_TREND_RST     = 8'd20;
    localparam t_trend FALL_TREND_RST     = 8'd10;

endpackage

### sv/bgcd_in_if.sv
// Sample channel of the battery charge gauge: valid, ready and one voltage.
// Depends on bgcd_pkg for the field type.
`timescale 1ns / 1ps

interface bgcd_in_if;
    logic          valid;
    logic          ready;
    bgcd_pkg::t_mv pack_mv;

    modport source (output valid, output pack_mv, input ready);
    modport sink   (input valid, input pack_mv, output ready);
endinterface

### sv/bgcd_out_if.sv
// Result channel of the battery charge gauge: percent, charge flags, average.
// Depends on bgcd_pkg for the field types.
`timescale 1ns / 1ps

interface bgcd_out_if;
    logic           valid;
    logic           ready;
    bgcd_pkg::t_pct charge_percent;
    logic           is_charging;
    logic           status_changed;
    bgcd_pkg::t_mv  smoothed_mv;

    modport source (output valid, output charge_percent, output is_charging,
                    output status_changed, output smoothed_mv, input ready);
    modport sink   (input valid, input charge_percent, input is_charging,
                    input status_changed, input smoothed_mv, output ready);
endinterface

### sv/battery_gauge_charge_detect.sv
// Top level of the battery charge gauge: sequencer around one multiplier.
// Depends on bgcd_pkg, bgcd_in_if and bgcd_out_if.
//
// Usage:
//   i_in carries one pack-voltage sample per beat; o_out returns one result
//   per sample: percent, charging flag, change flag and the averaged voltage.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while the
//   block is idle; index 0 is the full threshold, 1 the rise trend, 2 the
//   fall trend, index 3 is ignored.
//   A result comes soonest when both averages are loaded directly and the
//   percent clamps, and latest when all three passes through the shared
//   multiplier (fast step, interpolation product, slow step) and the four
//   restoring-division steps for the interpolation run.
//   A new sample is taken only once the last one has reached the output
//   register; i_in.ready is high only in the idle state.
//   A finished result sits in the output register; the next sample is taken
//   while it waits, and the sequencer holds at its last step until the
//   result register is free.
//   Reset restores the register defaults, clears both averages and the
//   charge flag and marks that no prior result exists.
`timescale 1ns / 1ps

module battery_gauge_charge_detect #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  bgcd_pkg::t_idx       i_cfg_idx,
    input  bgcd_pkg::t_mv        i_cfg_data,
    bgcd_in_if.sink              i_in,
    bgcd_out_if.source           o_out
);

    localparam int W  = bgcd_pkg::MV_W + FRAC_BITS;
    localparam int PW = W + 7;
    localparam int NW = W + 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FAST  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_APPLY = 4'd3;
    localparam logic [3:0] S_SEG   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SLOW  = 4'd6;
    localparam logic [3:0] S_FLAG  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [1:0] PH_FAST = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_SLOW = 2'd2;

    localparam logic [W-1:0] EMPTY_FX = {bgcd_pkg::EMPTY_MV, {FRAC_BITS{1'b0}}};

    logic [3:0]            r_state;
    logic [1:0]            r_phase;
    bgcd_pkg::t_mv         r_full_mv;
    bgcd_pkg::t_trend      r_rise_mv;
    bgcd_pkg::t_trend      r_fall_mv;
    logic [W-1:0]          r_sample;
    logic [W-1:0]          r_fast;
    logic [W-1:0]          r_slow;
    logic                  r_flag;
    logic                  r_charging;
    bgcd_pkg::t_pct        r_pct;
    bgcd_pkg::t_pct        r_prior_pct;
    logic                  r_prior_chg;
    logic [W-1:0]          r_diff;
    logic                  r_neg;
    logic [6:0]            r_k;
    logic [PW-1:0]         r_prod;
    bgcd_pkg::t_seg        r_seg;
    logic [NW-1:0]         r_num;
    logic [NW-1:0]         r_den2;
    logic [1:0]            r_bit;
    logic [3:0]            r_q;
    logic                  r_out_valid;
    bgcd_pkg::t_pct        r_out_pct;
    logic                  r_out_chg;
    logic                  r_out_changed;
    bgcd_pkg::t_mv         r_out_mv;

    logic [W-1:0]          n_cur;
    logic [W-1:0]          n_avg;
    logic [NW-1:0]         n_up_sum;
    logic [W-1:0]          n_up;
    logic [W-1:0]          n_down;
    bgcd_pkg::t_seg        n_seg;
    bgcd_pkg::t_seg        n_seg_hi;
    logic [W-1:0]          n_seg_lo_fx;
    logic [W-1:0]          n_den;
    logic [NW-1:0]         n_trial;
    logic                  n_below;
    logic                  n_above;
    logic [W:0]            n_rise_sum;
    logic [W:0]            n_fall_sum;
    logic                  in_beat;
    logic                  out_free;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.charge_percent = r_out_pct;
    assign o_out.is_charging    = r_out_chg;
    assign o_out.status_changed = r_out_changed;
    assign o_out.smoothed_mv    = r_out_mv;

    // average step: cur + floor(d*k/256) upward, cur - ceil(d*k/256) downward
    always_comb begin
        n_cur    = (r_phase == PH_SLOW) ? r_slow : r_fast;
        n_up_sum = {1'b0, r_prod} + NW'(255);
        n_up     = n_up_sum[NW-1:8];
        n_down   = {1'b0, r_prod[PW-1:8]};
        n_avg    = r_neg ? (n_cur - n_up) : (n_cur + n_down);
    end

    always_comb begin
        n_below = (r_fast <= {bgcd_pkg::OCV_MV[0], {FRAC_BITS{1'b0}}});
        n_above = (r_fast >= {bgcd_pkg::OCV_MV[bgcd_pkg::TABLE_N-1], {FRAC_BITS{1'b0}}});
        n_seg   = bgcd_pkg::t_seg'(bgcd_pkg::SEG_N - 1);
        for (int i = bgcd_pkg::SEG_N - 1; i >= 0; i--) begin
            if (r_fast < {bgcd_pkg::OCV_MV[i+1], {FRAC_BITS{1'b0}}}) begin
                n_seg = bgcd_pkg::t_seg'(i);
            end
        end
        n_seg_hi    = r_seg + bgcd_pkg::t_seg'(1);
        n_seg_lo_fx = {bgcd_pkg::OCV_MV[n_seg], {FRAC_BITS{1'b0}}};
        n_den       = {bgcd_pkg::OCV_MV[n_seg_hi] - bgcd_pkg::OCV_MV[r_seg],
                       {FRAC_BITS{1'b0}}};
        n_trial     = r_den2 << r_bit;
    end

    always_comb begin
        n_rise_sum = {1'b0, r_slow} + (W+1)'({r_rise_mv, {FRAC_BITS{1'b0}}});
        n_fall_sum = {1'b0, r_fast} + (W+1)'({r_fall_mv, {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FAST;
            r_full_mv   <= bgcd_pkg::FULL_THRESHOLD_RST;
            r_rise_mv   <= bgcd_pkg::RISE_TREND_RST;
            r_fall_mv   <= bgcd_pkg::FALL_TREND_RST;
            r_fast      <= '0;
            r_slow      <= '0;
            r_flag      <= 1'b0;
            r_prior_pct <= bgcd_pkg::PCT_NONE;
            r_prior_chg <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bgcd_pkg::REG_FULL_THRESHOLD: r_full_mv <= i_cfg_data;
                    bgcd_pkg::REG_RISE_TREND:
                        r_rise_mv <= i_cfg_data[bgcd_pkg::TREND_W-1:0];
                    bgcd_pkg::REG_FALL_TREND:
                        r_fall_mv <= i_cfg_data[bgcd_pkg::TREND_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_sample <= {i_in.pack_mv, {FRAC_BITS{1'b0}}};
                        r_state  <= S_FAST;
                    end
                end
                S_FAST: begin
                    if (r_fast <= EMPTY_FX) begin
                        r_fast  <= r_sample;
                        r_state <= S_SEG;
                    end else begin
                        r_neg   <= (r_sample < r_fast);
                        r_diff  <= (r_sample < r_fast) ? (r_fast - r_sample)
                                                       : (r_sample - r_fast);
                        r_k     <= bgcd_pkg::FAST_K;
                        r_phase <= PH_FAST;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_diff) * PW'(r_k);
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    case (r_phase)
                        PH_FAST: begin
                            r_fast  <= n_avg;
                            r_state <= S_SEG;
                        end
                        PH_PCT: begin
                            r_num   <= {r_prod, 1'b0} + NW'(n_den);
                            r_den2  <= NW'({n_den, 1'b0});
                            r_bit   <= 2'd3;
                            r_q     <= '0;
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_slow  <= n_avg;
                            r_state <= S_FLAG;
                        end
                    endcase
                end
                S_SEG: begin
                    if (n_below) begin
                        r_pct   <= '0;
                        r_state <= S_SLOW;
                    end else if (n_above) begin
                        r_pct   <= bgcd_pkg::PCT_MAX;
                        r_state <= S_SLOW;
                    end else begin
                        r_seg   <= n_seg;
                        r_diff  <= r_fast - n_seg_lo_fx;
                        r_k     <= 7'(bgcd_pkg::OCV_PCT[n_seg + bgcd_pkg::t_seg'(1)]
                                      - bgcd_pkg::OCV_PCT[n_seg]);
                        r_phase <= PH_PCT;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (r_num >= n_trial) begin
                        r_num        <= r_num - n_trial;
                        r_q[r_bit]   <= 1'b1;
                    end
                    if (r_bit == 2'd0) begin
                        r_pct   <= bgcd_pkg::OCV_PCT[r_seg]
                                 + {3'b000, r_q[3:1], (r_num >= n_trial)};
                        r_state <= S_SLOW;
                    end else begin
                        r_bit <= r_bit - 2'd1;
                    end
                end
                S_SLOW: begin
                    if (r_slow <= EMPTY_FX) begin
                        r_slow     <= r_fast;
                        r_charging <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_neg   <= (r_fast < r_slow);
                        r_diff  <= (r_fast < r_slow) ? (r_slow - r_fast)
                                                     : (r_fast - r_slow);
                        r_k     <= bgcd_pkg::SLOW_K;
                        r_phase <= PH_SLOW;
                        r_state <= S_MUL;
                    end
                end
                S_FLAG: begin
                    if (({1'b0, r_fast} > n_rise_sum) ||
                        (r_fast >= {r_full_mv, {FRAC_BITS{1'b0}}})) begin
                        r_flag     <= 1'b1;
                        r_charging <= 1'b1;
                    end else if (n_fall_sum < {1'b0, r_slow}) begin
                        r_flag     <= 1'b0;
                        r_charging <= 1'b0;
                    end else begin
                        r_charging <= r_flag;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_pct     <= r_pct;
                        r_out_chg     <= r_charging;
                        r_out_changed <= (r_pct != r_prior_pct) ||
                                         (r_charging != r_prior_chg);
                        r_out_mv      <= r_fast[W-1:FRAC_BITS];
                        r_prior_pct   <= r_pct;
                        r_prior_chg   <= r_charging;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in.ready)
        else $error("sample taken while sequencer busy");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.charge_percent <= bgcd_pkg::PCT_MAX))
        else $error("percent above full scale");

    a_prior_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prior_pct == bgcd_pkg::PCT_NONE) || (r_prior_pct <= bgcd_pkg::PCT_MAX))
        else $error("prior percent holds an invalid code");

    a_result_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out.valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

### verif/tb_battery_gauge_charge_detect.sv
// Testbench for battery_gauge_charge_detect: voltage ramps, noise and dropouts
// drive the sample channel; a scoreboard predicts every result and checks it.
// Depends on bgcd_pkg, bgcd_in_if, bgcd_out_if and the top-level RTL.
`timescale 1ns / 1ps

module tb_battery_gauge_charge_detect;

    localparam int FRAC_BITS       = 8;
    localparam int SETTLE_CYCLES   = 20;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASE_SAMPLES   = 150;
    localparam int PHASE_N         = 8;
    localparam int HOLD_OFF_AT     = 500;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam bgcd_pkg::t_idx REG_UNUSED = 2'd3;

    typedef struct packed {
        bgcd_pkg::t_pct pct;
        logic           chg;
        logic           changed;
        bgcd_pkg::t_mv  mv;
    } t_gauge_reading;

    class charge_gauge_scoreboard;
        bgcd_pkg::t_mv    full_thr;
        bgcd_pkg::t_trend rise_mv;
        bgcd_pkg::t_trend fall_mv;
        longint unsigned  fast_avg;
        longint unsigned  slow_base;
        bit               charge_flag;
        bit               prior_chg;
        bgcd_pkg::t_pct   prior_pct;
        t_gauge_reading   expected_readings[$];
        int               errors;
        int               charging_seen;

        function new();
            full_thr      = bgcd_pkg::FULL_THRESHOLD_RST;
            rise_mv       = bgcd_pkg::RISE_TREND_RST;
            fall_mv       = bgcd_pkg::FALL_TREND_RST;
            fast_avg      = 0;
            slow_base     = 0;
            charge_flag   = 1'b0;
            prior_chg     = 1'b0;
            prior_pct     = bgcd_pkg::PCT_NONE;
            errors        = 0;
            charging_seen = 0;
        endfunction

        function void write_reg(bgcd_pkg::t_idx idx, bgcd_pkg::t_mv data);
            case (idx)
                bgcd_pkg::REG_FULL_THRESHOLD: full_thr = data;
                bgcd_pkg::REG_RISE_TREND:     rise_mv  = data[bgcd_pkg::TREND_W-1:0];
                bgcd_pkg::REG_FALL_TREND:     fall_mv  = data[bgcd_pkg::TREND_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned to_fx(longint unsigned mv);
            return mv << FRAC_BITS;
        endfunction

        function longint unsigned step_toward(longint unsigned cur, longint unsigned target,
                                              longint unsigned k);
            if (target >= cur)
                return cur + (((target - cur) * k) >> 8);
            return cur - ((((cur - target) * k) + 255) >> 8);
        endfunction

        function bgcd_pkg::t_pct percent_of(longint unsigned v);
            longint unsigned num;
            longint unsigned den;
            if (v <= to_fx(bgcd_pkg::OCV_MV[0]))
                return '0;
            if (v >= to_fx(bgcd_pkg::OCV_MV[bgcd_pkg::TABLE_N-1]))
                return bgcd_pkg::PCT_MAX;
            for (int i = 0; i < bgcd_pkg::SEG_N; i++) begin
                if (v < to_fx(bgcd_pkg::OCV_MV[i+1])) begin
                    num = (v - to_fx(bgcd_pkg::OCV_MV[i]))
                        * longint'(bgcd_pkg::OCV_PCT[i+1] - bgcd_pkg::OCV_PCT[i]);
                    den = to_fx(bgcd_pkg::OCV_MV[i+1] - bgcd_pkg::OCV_MV[i]);
                    return bgcd_pkg::OCV_PCT[i]
                         + bgcd_pkg::t_pct'((2 * num + den) / (2 * den));
                end
            end
            return bgcd_pkg::PCT_MAX;
        endfunction

        function void predict_reading(bgcd_pkg::t_mv sample);
            longint unsigned s;
            t_gauge_reading  r;
            bit              chg;
            s = to_fx(sample);
            if (fast_avg <= to_fx(bgcd_pkg::EMPTY_MV))
                fast_avg = s;
            else
                fast_avg = step_toward(fast_avg, s, bgcd_pkg::FAST_K);
            r.pct = percent_of(fast_avg);
            if (slow_base <= to_fx(bgcd_pkg::EMPTY_MV)) begin
                slow_base = fast_avg;
                chg = 1'b0;
            end else begin
                slow_base = step_toward(slow_base, fast_avg, bgcd_pkg::SLOW_K);
                if (fast_avg > slow_base + to_fx(rise_mv) || fast_avg >= to_fx(full_thr))
                    charge_flag = 1'b1;
                else if (fast_avg + to_fx(fall_mv) < slow_base)
                    charge_flag = 1'b0;
                chg = charge_flag;
            end
            r.chg     = chg;
            r.changed = (r.pct != prior_pct) || (chg != prior_chg);
            r.mv      = bgcd_pkg::t_mv'(fast_avg >> FRAC_BITS);
            prior_pct = r.pct;
            prior_chg = chg;
            charging_seen += chg;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(bgcd_pkg::t_pct pct, logic chg, logic changed,
                                    bgcd_pkg::t_mv mv);
            t_gauge_reading e;
            if (expected_readings.size() == 0) begin
                $error("unexpected result: charge_percent %0d smoothed_mv %0d", pct, mv);
                errors++;
                return;
            end
            e = expected_readings.pop_front();
            if (pct !== e.pct) begin
                $error("charge_percent: expected %0d, got %0d", e.pct, pct);
                errors++;
            end
            if (chg !== e.chg) begin
                $error("is_charging: expected %0b, got %0b", e.chg, chg);
                errors++;
            end
            if (changed !== e.changed) begin
                $error("status_changed: expected %0b, got %0b", e.changed, changed);
                errors++;
            end
            if (mv !== e.mv) begin
                $error("smoothed_mv: expected %0d, got %0d", e.mv, mv);
                errors++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           cfg_we;
    bgcd_pkg::t_idx cfg_idx;
    bgcd_pkg::t_mv  cfg_data;

    bgcd_in_if  sample_ch ();
    bgcd_out_if reading_ch ();

    charge_gauge_scoreboard sb = new();

    bit quiet_mode;
    bit hold_off_done;
    int samples_sent;
    int results_seen;
    int settings_done;
    int dropouts_done;

    battery_gauge_charge_detect #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch),
        .o_out      (reading_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 98)
            return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic bgcd_pkg::t_mv clamp_mv(int v);
        if (v < 0)
            return '0;
        if (v > 8191)
            return 13'd8191;
        return bgcd_pkg::t_mv'(v);
    endfunction

    task automatic send_sample(input bgcd_pkg::t_mv v);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.pack_mv = v;
        sample_ch.valid   = 1'b1;
        do @(posedge i_clk); while (!sample_ch.ready);
        sb.predict_reading(v);
        samples_sent++;
    endtask

    // Hold the pack low long enough for both averages to empty.
    task automatic send_dropout(inout int sent);
        int len;
        len = $urandom_range(80, 110);
        for (int k = 0; k < len; k++) begin
            send_sample(bgcd_pkg::t_mv'($urandom_range(0, bgcd_pkg::EMPTY_MV)));
            sent++;
        end
        dropouts_done++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bgcd_pkg::t_idx idx, input bgcd_pkg::t_mv data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input bgcd_pkg::t_mv full, input bgcd_pkg::t_mv rise,
                                input bgcd_pkg::t_mv fall);
        settle();
        write_reg(bgcd_pkg::REG_FULL_THRESHOLD, full);
        write_reg(bgcd_pkg::REG_RISE_TREND, rise);
        write_reg(bgcd_pkg::REG_FALL_TREND, fall);
        write_reg(REG_UNUSED, bgcd_pkg::t_mv'($urandom));
        @(negedge i_clk);
        cfg_we = 1'b0;
        settings_done++;
    endtask

    task automatic run_sequences(input int budget);
        int sent;
        int kind;
        int len;
        int lvl;
        int slope;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                send_dropout(sent);
            end else if (kind < 73) begin
                lvl   = $urandom_range(3000, 4250);
                slope = $urandom_range(0, 40);
                if (kind >= 43)
                    slope = -slope;
                len = $urandom_range(10, 40);
                for (int k = 0; k < len; k++) begin
                    send_sample(clamp_mv(lvl + k * slope + $urandom_range(0, 6) - 3));
                    sent++;
                end
            end else if (kind < 88) begin
                lvl = $urandom_range(3000, 4300);
                len = $urandom_range(10, 30);
                for (int k = 0; k < len; k++) begin
                    send_sample(clamp_mv(lvl + $urandom_range(0, 16) - 8));
                    sent++;
                end
            end else begin
                len = $urandom_range(5, 20);
                for (int k = 0; k < len; k++) begin
                    send_sample(bgcd_pkg::t_mv'($urandom_range(0, 8191)));
                    sent++;
                end
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
                reading_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
                reading_ch.ready = 1'b1;
            end else if (stall > 0) begin
                reading_ch.ready = 1'b0;
                stall--;
            end else begin
                reading_ch.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (reading_ch.valid && reading_ch.ready) begin
            sb.check_reading(reading_ch.charge_percent, reading_ch.is_charging,
                             reading_ch.status_changed, reading_ch.smoothed_mv);
            results_seen++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((sample_ch.valid && sample_ch.ready) || (reading_ch.valid && reading_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $error("no beat on either channel for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        bgcd_pkg::t_mv corner_samples[$];
        corner_samples = '{
            13'd0, 13'd100, 13'd8191, 13'd8191, 13'd0, 13'd0, 13'd3300, 13'd3300,
            13'd3450, 13'd3550, 13'd3660, 13'd3700, 13'd3740, 13'd3780, 13'd3820,
            13'd3870, 13'd3950, 13'd4080, 13'd4200, 13'd4200, 13'd4150, 13'd5461,
            13'd2730, 13'd101
        };
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = bgcd_pkg::REG_FULL_THRESHOLD;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.pack_mv = '0;
        reading_ch.ready  = 1'b0;
        quiet_mode        = 1'b0;
        hold_off_done     = 1'b0;
        samples_sent      = 0;
        results_seen      = 0;
        settings_done     = 0;
        dropouts_done     = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (corner_samples[k])
            send_sample(corner_samples[k]);

        for (int phase = 0; phase < PHASE_N; phase++) begin
            case (phase)
                0: program_regs(13'd8191, 13'd255, 13'd255);
                1: program_regs(13'd0, 13'd0, 13'd0);
                2: program_regs(bgcd_pkg::FULL_THRESHOLD_RST, bgcd_pkg::RISE_TREND_RST,
                                bgcd_pkg::FALL_TREND_RST);
                3: program_regs(13'd4000, 13'd0, 13'd255);
                4: program_regs(13'd8191, 13'd255, 13'd0);
                default: program_regs(bgcd_pkg::t_mv'($urandom_range(3800, 8191)),
                                      bgcd_pkg::t_mv'($urandom),
                                      bgcd_pkg::t_mv'($urandom));
            endcase
            quiet_mode = (phase == 2);
            if (phase == 3) begin
                int forced;
                forced = 0;
                send_dropout(forced);
            end
            run_sequences(PHASE_SAMPLES);
        end

        quiet_mode = 1'b0;
        settle();
        $display("Sent %0d samples over %0d register settings with %0d dropouts;",
                 samples_sent, settings_done, dropouts_done);
        $display("checked %0d results, %0d of them reporting charging.",
                 results_seen, sb.charging_seen);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### battery_gauge_charge_detect.f
sv/bgcd_pkg.sv
sv/bgcd_in_if.sv
sv/bgcd_out_if.sv
sv/battery_gauge_charge_detect.sv
verif/tb_battery_gauge_charge_detect.sv
